>>> rtl/sha1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 package
// Types and constants shared by the SHA-1 front end, queue and engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  // Request handed from the front end to the engine.
  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } sha1_req_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

>>> rtl/sha1_message_digest_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest core
// Byte-serial SHA-1 with a request queue in front of the compression engine.
// ----------------------------------------------------------------------------
// An append request stores one byte in the block buffer; the 64th byte of a
// block starts a compression (one SHA-1 round per cycle in the engine), and
// the engine takes no further request from the queue until it is done. A finish
// request pads through a sweep of the block buffer, compresses one or two
// blocks and then presents the five digest words, index 0 first.
module sha1_message_digest_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic                q_valid;
  logic                q_pop;
  sha1_pkg::sha1_req_t q_req;

  sha1_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_byte_value,
    .q_valid, .q_pop, .q_req
  );

  sha1_engine u_engine (
    .clk, .rst_n, .q_valid, .q_pop, .q_req,
    .out_valid, .out_stall, .out_digest_word, .out_word_index, .out_last_word
  );

endmodule

>>> rtl/sha1_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts input requests, classifies them and places them in a short queue.
// ----------------------------------------------------------------------------
module sha1_front #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [7:0]         in_byte_value,
  output logic               q_valid,
  input  logic               q_pop,
  output sha1_pkg::sha1_req_t q_req
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha1_pkg::sha1_req_t mem_r [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r;
  logic          push;
  logic          pop;

  assign in_stall = (cnt_r == (AW+1)'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_req    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r].finish <= (in_action == sha1_pkg::ACT_FINISH);
      mem_r[wr_r].data   <= in_byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == AW'(DEPTH-1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == AW'(DEPTH-1)) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

>>> rtl/sha1_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 engine
// Buffers bytes, pads, runs one compression round per cycle and emits the
// digest words from the hash state registers.
// ----------------------------------------------------------------------------
module sha1_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  sha1_pkg::sha1_req_t q_req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_digest_word,
  output logic [2:0]         out_word_index,
  output logic               out_last_word
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [5:0]    fill_r;
  logic [63:0]   len_r;
  logic [63:0]   total_r;
  logic [31:0]   h_r [5];
  logic [31:0]   a_r, b_r, c_r, d_r, e_r;
  logic [31:0]   w_r [16];
  logic [6:0]    rnd_r;
  logic [5:0]    pidx_r;
  logic          fin_r;      // compression belongs to a finish request
  logic          extra_r;    // a second padded block is still due
  logic          padded_r;   // the 0x80 marker has been placed
  logic [2:0]    widx_r;

  logic [31:0] f, k, t, wn;
  logic        take_byte;

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign take_byte = q_pop && !q_req.finish;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = sha1_pkg::K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = sha1_pkg::K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = sha1_pkg::K2;
    end else begin
      f = b_r ^ c_r ^ d_r; k = sha1_pkg::K3;
    end
    t  = sha1_pkg::rotl(a_r, 5) + f + e_r + k + w_r[0];
    wn = sha1_pkg::rotl(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          if (q_req.finish) state_nxt = ST_PAD;
          else if (fill_r == 6'd63) state_nxt = ST_LOAD;
        end
      end
      ST_PAD:   if (pidx_r == 6'd63) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 7'd79) state_nxt = ST_ADD;
      ST_ADD: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (extra_r) state_nxt = ST_PAD;
        else state_nxt = ST_EMIT;
      end
      ST_EMIT:  if (!out_stall && widx_r == 3'd4) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // The message block is collected straight into the schedule words, most
  // significant byte first; padding fills every byte from the fill point
  // upwards (all of a second block), and length bytes end the last block.
  always_ff @(posedge clk) begin
    if (state_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
      e_r <= d_r; d_r <= c_r; c_r <= sha1_pkg::rotl(b_r, 30); b_r <= a_r; a_r <= t;
    end else begin
      if (take_byte) w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= q_req.data;
      if (state_r == ST_PAD) begin
        if (pidx_r >= 6'd56 && !extra_r)
          w_r[pidx_r[5:2]][{~pidx_r[1:0], 3'b000} +: 8] <=
            total_r[{~pidx_r[2:0], 3'b000} +: 8];
        else if (padded_r)
          w_r[pidx_r[5:2]][{~pidx_r[1:0], 3'b000} +: 8] <= 8'h00;
        else if (pidx_r == fill_r)
          w_r[pidx_r[5:2]][{~pidx_r[1:0], 3'b000} +: 8] <= sha1_pkg::PAD_BYTE;
      end
      if (state_r == ST_LOAD) begin
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      len_r    <= '0;
      total_r  <= '0;
      rnd_r    <= '0;
      pidx_r   <= '0;
      fin_r    <= 1'b0;
      extra_r  <= 1'b0;
      padded_r <= 1'b0;
      widx_r   <= '0;
      h_r[0] <= sha1_pkg::H0; h_r[1] <= sha1_pkg::H1; h_r[2] <= sha1_pkg::H2;
      h_r[3] <= sha1_pkg::H3; h_r[4] <= sha1_pkg::H4;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_req.finish) begin
              fin_r    <= 1'b1;
              extra_r  <= (fill_r >= 6'd56);
              padded_r <= 1'b0;
              total_r  <= len_r + {55'd0, fill_r, 3'd0};
              pidx_r   <= '0;
            end else begin
              fin_r  <= 1'b0;
              fill_r <= fill_r + 1'b1;
              if (fill_r == 6'd63) len_r <= len_r + 64'd512;
            end
          end
        end
        ST_PAD: begin
          if (pidx_r == fill_r) padded_r <= 1'b1;
          pidx_r <= pidx_r + 1'b1;
        end
        ST_LOAD:  rnd_r <= '0;
        ST_ROUND: rnd_r <= rnd_r + 1'b1;
        ST_ADD: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
          extra_r <= 1'b0;
          padded_r <= 1'b1;
          pidx_r  <= '0;
          widx_r  <= '0;
        end
        ST_EMIT: begin
          if (!out_stall) begin
            widx_r <= widx_r + 1'b1;
            if (widx_r == 3'd4) begin
              fill_r <= '0;
              len_r  <= '0;
              fin_r  <= 1'b0;
              h_r[0] <= sha1_pkg::H0; h_r[1] <= sha1_pkg::H1; h_r[2] <= sha1_pkg::H2;
              h_r[3] <= sha1_pkg::H3; h_r[4] <= sha1_pkg::H4;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = (state_r == ST_EMIT);
  assign out_digest_word = h_r[widx_r];
  assign out_word_index  = widx_r;
  assign out_last_word   = (widx_r == 3'd4);

endmodule
